// File: design/rss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rss_pkg
// Shared types and constants for the running sample statistics block.
// ----------------------------------------------------------------------------
package rss_pkg;
  localparam int unsigned CountBits = 32;
  localparam int unsigned AccBits = 64;
  localparam int unsigned OutBits = 32;
  localparam int unsigned ScaleBits = 16;

  localparam logic [0:0] RegScaleDivisor = 1'b0;

  // job handed from the front end to the back end through the queue
  typedef struct packed {
    logic [CountBits-1:0] count;
    logic [AccBits-1:0] sum;
    logic [AccBits-1:0] square_sum;
    logic [31:0] smallest;
    logic [31:0] largest;
    logic overflowed;
  } job_t;

  typedef struct packed {
    logic [OutBits-1:0] count;
    logic [OutBits-1:0] min_scaled;
    logic [OutBits-1:0] max_scaled;
    logic [OutBits-1:0] mean_scaled;
    logic [OutBits-1:0] deviation_scaled;
    logic overflowed;
  } result_t;

  typedef enum logic [3:0] {
    BE_IDLE, BE_MULA, BE_MULB, BE_VAR, BE_SQRT, BE_DIV_MIN, BE_DIV_MAX,
    BE_DIV_MEAN, BE_DIV_DEV, BE_DONE
  } be_state_t;
endpackage
`default_nettype wire

// File: design/rss_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rss_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface rss_stream_if #(
  parameter type payload_t = logic
);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/rss_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rss_front
// Accepts samples, updates accumulators and min/max, queues a job.
// ----------------------------------------------------------------------------
module rss_front #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_ready,
  input wire logic [SAMPLE_BITS-1:0] in_sample,
  output logic job_valid,
  input wire logic job_ready,
  output rss_pkg::job_t job
);
  logic [rss_pkg::CountBits-1:0] sample_count;
  logic [rss_pkg::AccBits-1:0] running_sum;
  logic [rss_pkg::AccBits-1:0] running_square_sum;
  logic [SAMPLE_BITS-1:0] largest_seen;
  logic [SAMPLE_BITS-1:0] smallest_seen;

  logic [2*SAMPLE_BITS-1:0] sq;
  logic [rss_pkg::AccBits:0] sum_ext;
  logic [rss_pkg::AccBits:0] sq_ext;
  logic ovf;
  logic take;
  rss_pkg::job_t job_next;

  assign in_ready = !job_valid || job_ready;
  assign take = in_valid && in_ready;
  assign sq = in_sample * in_sample;
  assign sum_ext = {1'b0, running_sum} + (rss_pkg::AccBits+1)'(in_sample);
  assign sq_ext = {1'b0, running_square_sum} + (rss_pkg::AccBits+1)'(sq);
  assign ovf = (&sample_count) || sum_ext[rss_pkg::AccBits] || sq_ext[rss_pkg::AccBits];

  always_comb begin
    job_next.overflowed = ovf;
    if (ovf) begin
      job_next.count = '0;
      job_next.sum = '0;
      job_next.square_sum = '0;
      job_next.largest = 32'(largest_seen);
      job_next.smallest = 32'(smallest_seen);
    end else begin
      job_next.count = sample_count + 1'b1;
      job_next.sum = sum_ext[rss_pkg::AccBits-1:0];
      job_next.square_sum = sq_ext[rss_pkg::AccBits-1:0];
      job_next.largest = (in_sample > largest_seen) ? 32'(in_sample) : 32'(largest_seen);
      job_next.smallest = (in_sample < smallest_seen || smallest_seen == '0) ?
                          32'(in_sample) : 32'(smallest_seen);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      running_sum <= '0;
      running_square_sum <= '0;
      largest_seen <= '0;
      smallest_seen <= '0;
      job_valid <= 1'b0;
    end else begin
      if (take) begin
        sample_count <= job_next.count;
        running_sum <= job_next.sum;
        running_square_sum <= job_next.square_sum;
        largest_seen <= job_next.largest[SAMPLE_BITS-1:0];
        smallest_seen <= job_next.smallest[SAMPLE_BITS-1:0];
        job_valid <= 1'b1;
      end else if (job_ready) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) job <= job_next;
  end
endmodule
`default_nettype wire

// File: design/rss_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rss_back
// Scales min/max, computes mean and deviation with a shared serial divider,
// a radix-2 square root and a 32x32 multiplier used over several cycles.
// ----------------------------------------------------------------------------
module rss_back #(
  parameter int unsigned FRAC_BITS = 8
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic [rss_pkg::ScaleBits-1:0] scale_divisor,
  input wire logic job_valid,
  output logic job_ready,
  input wire rss_pkg::job_t job,
  output logic res_valid,
  input wire logic res_ready,
  output rss_pkg::result_t res
);
  localparam int unsigned NumBits = rss_pkg::AccBits + FRAC_BITS;
  localparam int unsigned StepBits = $clog2(NumBits + 1);

  rss_pkg::be_state_t state, state_next;
  rss_pkg::job_t cur;
  logic [rss_pkg::ScaleBits-1:0] scl;
  logic [47:0] dvs;
  // 64x64 products built from four 32x32 partial products
  logic [2:0] part;
  logic [1:0] part_prev;
  logic [63:0] ca, cb;
  logic [31:0] mx, my;
  logic [63:0] pp;
  logic [127:0] pp_sh;
  logic [127:0] acc;
  logic [127:0] prod_a;
  // square root, two radicand bits per step
  logic [127:0] var_v;
  logic [65:0] sq_rem;
  logic [67:0] sq_try;
  logic [67:0] sq_trial;
  logic [63:0] root;
  // restoring divider
  logic [NumBits-1:0] dnum;
  logic [47:0] rem;
  logic [48:0] rem_sh;
  logic [NumBits-1:0] quo;
  logic [47:0] divisor_sel;
  logic [rss_pkg::OutBits-1:0] dq;
  logic dbusy;
  logic [StepBits-1:0] step;
  logic [rss_pkg::OutBits-1:0] q_min, q_max, q_mean, q_dev;
  logic div_last;
  logic res_load;

  always_comb begin
    state_next = state;
    unique case (state)
      rss_pkg::BE_IDLE: if (job_valid) state_next = rss_pkg::BE_MULA;
      rss_pkg::BE_MULA: if (part == 3'd4) state_next = rss_pkg::BE_MULB;
      rss_pkg::BE_MULB: if (part == 3'd4) state_next = rss_pkg::BE_VAR;
      rss_pkg::BE_VAR: state_next = rss_pkg::BE_SQRT;
      rss_pkg::BE_SQRT: if (step == StepBits'(63)) state_next = rss_pkg::BE_DIV_MIN;
      rss_pkg::BE_DIV_MIN: if (div_last) state_next = rss_pkg::BE_DIV_MAX;
      rss_pkg::BE_DIV_MAX: if (div_last) state_next = rss_pkg::BE_DIV_MEAN;
      rss_pkg::BE_DIV_MEAN: if (div_last) state_next = rss_pkg::BE_DIV_DEV;
      rss_pkg::BE_DIV_DEV: if (div_last) state_next = rss_pkg::BE_DONE;
      rss_pkg::BE_DONE: if (!res_valid || res_ready) state_next = rss_pkg::BE_IDLE;
      default: state_next = rss_pkg::BE_IDLE;
    endcase
  end

  always_comb begin
    job_ready = (state == rss_pkg::BE_IDLE);
    res_load = (state == rss_pkg::BE_DONE) && (!res_valid || res_ready);
    div_last = dbusy && (step == '0);
  end

  // multiplier operand selection: part picks the 32-bit halves
  always_comb begin
    if (state == rss_pkg::BE_MULA) begin
      ca = 64'(cur.count);
      cb = cur.square_sum;
    end else begin
      ca = cur.sum;
      cb = cur.sum;
    end
    mx = part[1] ? ca[63:32] : ca[31:0];
    my = part[0] ? cb[63:32] : cb[31:0];
  end

  always_ff @(posedge clk) begin
    pp <= mx * my;
  end

  // pp belongs to the part issued in the previous cycle
  assign part_prev = 2'(part - 3'd1);
  always_comb begin
    unique case (part_prev)
      2'd0: pp_sh = 128'(pp);
      2'd1, 2'd2: pp_sh = 128'(pp) << 32;
      default: pp_sh = 128'(pp) << 64;
    endcase
  end

  assign sq_try = {sq_rem, var_v[127:126]};
  assign sq_trial = {2'b00, root, 2'b01};
  assign rem_sh = {rem, dnum[NumBits-1]};
  assign divisor_sel = (state == rss_pkg::BE_DIV_MIN || state == rss_pkg::BE_DIV_MAX) ?
                       48'(scl) : dvs;
  assign dq = (|quo[NumBits-1:rss_pkg::OutBits]) ? '1 : quo[rss_pkg::OutBits-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rss_pkg::BE_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      rss_pkg::BE_IDLE: begin
        cur <= job;
        scl <= (scale_divisor == '0) ? 16'd1 : scale_divisor;
        dvs <= 48'(job.count) * 48'((scale_divisor == '0) ? 16'd1 : scale_divisor);
        part <= '0;
        acc <= '0;
        dbusy <= 1'b0;
      end
      rss_pkg::BE_MULA, rss_pkg::BE_MULB: begin
        if (part == 3'd4) begin
          part <= '0;
          if (state == rss_pkg::BE_MULA) begin
            prod_a <= acc + pp_sh;
            acc <= '0;
          end else begin
            acc <= acc + pp_sh;
          end
        end else begin
          part <= part + 3'd1;
          if (part != 3'd0) acc <= acc + pp_sh;
        end
      end
      rss_pkg::BE_VAR: begin
        var_v <= (acc <= prod_a) ? prod_a - acc : '0;
        sq_rem <= '0;
        root <= '0;
        step <= '0;
      end
      rss_pkg::BE_SQRT: begin
        if (sq_try >= sq_trial) begin
          sq_rem <= 66'(sq_try - sq_trial);
          root <= {root[62:0], 1'b1};
        end else begin
          sq_rem <= sq_try[65:0];
          root <= {root[62:0], 1'b0};
        end
        var_v <= var_v << 2;
        step <= step + 1'b1;
      end
      rss_pkg::BE_DIV_MIN, rss_pkg::BE_DIV_MAX, rss_pkg::BE_DIV_MEAN,
      rss_pkg::BE_DIV_DEV: begin
        if (!dbusy) begin
          dbusy <= 1'b1;
          rem <= '0;
          quo <= '0;
          step <= StepBits'(NumBits);
          unique case (state)
            rss_pkg::BE_DIV_MIN: dnum <= NumBits'(cur.smallest) << FRAC_BITS;
            rss_pkg::BE_DIV_MAX: dnum <= NumBits'(cur.largest) << FRAC_BITS;
            rss_pkg::BE_DIV_MEAN: dnum <= NumBits'(cur.sum) << FRAC_BITS;
            default: dnum <= NumBits'(root) << FRAC_BITS;
          endcase
        end else if (step != '0) begin
          dnum <= dnum << 1;
          step <= step - 1'b1;
          if (rem_sh >= 49'(divisor_sel)) begin
            rem <= 48'(rem_sh - 49'(divisor_sel));
            quo <= {quo[NumBits-2:0], 1'b1};
          end else begin
            rem <= rem_sh[47:0];
            quo <= {quo[NumBits-2:0], 1'b0};
          end
        end else begin
          dbusy <= 1'b0;
          unique case (state)
            rss_pkg::BE_DIV_MIN: q_min <= dq;
            rss_pkg::BE_DIV_MAX: q_max <= dq;
            rss_pkg::BE_DIV_MEAN: q_mean <= (cur.count == '0) ? '0 : dq;
            default: q_dev <= (cur.count == '0) ? '0 : dq;
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res.count <= cur.count;
      res.min_scaled <= q_min;
      res.max_scaled <= q_max;
      res.mean_scaled <= q_mean;
      res.deviation_scaled <= q_dev;
      res.overflowed <= cur.overflowed;
    end
  end
endmodule
`default_nettype wire

// File: design/running_sample_statistics.sv
`default_nettype none
// ----------------------------------------------------------------------------
// running_sample_statistics
// Running count, min, max, mean and deviation over a sample stream.
// ----------------------------------------------------------------------------
// channel   | dir | payload
// in_ch     | in  | sample
// out_ch    | out | count, min/max/mean/deviation scaled, overflowed
// apb       | in  | scale_divisor at address 0
// The back end handles a sample in these steps: two 64x64 products, a variance
// state, 64 root steps and four restoring divisions, plus an idle and a done state.
// The front end holds one sample in its queue; later samples stall until the back
// end takes it, and the back end waits in done while the output register is full.
// Reset (rst, synchronous) clears the statistics and sets scale_divisor to 1.
module running_sample_statistics #(
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned FRAC_BITS = 8
) (
  input wire logic clk,
  input wire logic rst,
  rss_stream_if.sink in_ch,
  rss_stream_if.source out_ch,
  input wire logic psel,
  input wire logic penable,
  input wire logic pwrite,
  input wire logic [1:0] paddr,
  input wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  logic [rss_pkg::ScaleBits-1:0] scale_divisor;
  logic job_valid, job_ready;
  rss_pkg::job_t job;

  assign pready = 1'b1;
  assign prdata = (paddr[1] == rss_pkg::RegScaleDivisor) ? 32'(scale_divisor) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) scale_divisor <= 16'd1;
    else if (psel && penable && pwrite && paddr[1] == rss_pkg::RegScaleDivisor)
      scale_divisor <= pwdata[rss_pkg::ScaleBits-1:0];
  end

  rss_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_sample(in_ch.data), .job_valid, .job_ready, .job
  );

  rss_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst, .scale_divisor, .job_valid, .job_ready, .job,
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(out_ch.data)
  );

`ifndef SYNTHESIS
  a_no_job_loss: assert property (@(posedge clk) disable iff (rst)
    job_valid && !job_ready |=> job_valid) else $error("queued job dropped");
  a_ovf_clears: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.data.overflowed |-> out_ch.data.count == '0)
    else $error("overflow without clear");
`endif
endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives sample streams through running_sample_statistics under several scale
// settings and random stalls on both sides, predicts each result from shadow
// statistics, and compares each returned result as a whole against its prediction.
// ----------------------------------------------------------------------------
module testbench;
  localparam int unsigned SampleBits = 24;
  localparam int unsigned FracBits = 8;
  localparam int unsigned DrainCycles = 1500;
  localparam longint unsigned CycleLimit = 64'd8_000_000;

  typedef logic [SampleBits-1:0] sample_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  rss_stream_if #(.payload_t(sample_t)) in_ch ();
  rss_stream_if #(.payload_t(rss_pkg::result_t)) out_ch ();

  running_sample_statistics #(
    .SAMPLE_BITS(SampleBits),
    .FRAC_BITS(FracBits)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // shadow statistics
  logic [31:0] shadow_count;
  logic [63:0] shadow_sum;
  logic [63:0] shadow_square_sum;
  logic [23:0] shadow_largest;
  logic [23:0] shadow_smallest;
  logic [15:0] shadow_scale;

  sample_t pending_samples[$];
  rss_pkg::result_t expected_results[$];
  int unsigned mismatches;
  int unsigned samples_sent;
  int unsigned results_seen;
  int unsigned stall_mode;
  int unsigned hold_cycles;
  longint unsigned cycle_count;

  function automatic logic [31:0] div_saturate(logic [127:0] num, logic [63:0] den);
    logic [127:0] q;
    q = num / den;
    return (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic logic [63:0] root64(logic [127:0] v);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (128'(c) * 128'(c) <= v) r = c;
    end
    return r;
  endfunction

  // updates the shadow statistics with one sample and forms its result
  function automatic rss_pkg::result_t stats_update(sample_t s);
    rss_pkg::result_t res;
    logic [63:0] sq;
    logic [64:0] new_sum;
    logic [64:0] new_sq;
    logic ovf;
    logic [63:0] scale;
    logic [63:0] den;
    logic [127:0] prod_a;
    logic [127:0] prod_b;
    sq = 64'(s) * 64'(s);
    new_sum = 65'(shadow_sum) + 65'(s);
    new_sq = 65'(shadow_square_sum) + 65'(sq);
    ovf = (shadow_count == 32'hFFFF_FFFF) || new_sum[64] || new_sq[64];
    scale = (shadow_scale == 0) ? 64'd1 : 64'(shadow_scale);
    if (ovf) begin
      shadow_count = '0;
      shadow_sum = '0;
      shadow_square_sum = '0;
    end else begin
      shadow_count = shadow_count + 32'd1;
      shadow_sum = new_sum[63:0];
      shadow_square_sum = new_sq[63:0];
      if (s > shadow_largest) shadow_largest = s;
      if (s < shadow_smallest || shadow_smallest == 0) shadow_smallest = s;
    end
    res = '0;
    res.count = shadow_count;
    res.min_scaled = div_saturate(128'(shadow_smallest) << FracBits, scale);
    res.max_scaled = div_saturate(128'(shadow_largest) << FracBits, scale);
    res.overflowed = ovf;
    if (shadow_count != 0) begin
      den = 64'(shadow_count) * scale;
      res.mean_scaled = div_saturate(128'(shadow_sum) << FracBits, den);
      prod_a = 128'(shadow_count) * 128'(shadow_square_sum);
      prod_b = 128'(shadow_sum) * 128'(shadow_sum);
      if (prod_b <= prod_a)
        res.deviation_scaled = div_saturate(128'(root64(prod_a - prod_b)) << FracBits, den);
    end
    return res;
  endfunction

  function automatic bit roll(int unsigned pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(3, 0))
      0: return sample_t'($urandom_range(255, 0));
      1: return sample_t'(24'hFFFFFF - $urandom_range(255, 0));
      default: return sample_t'($urandom);
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(stats_update(in_ch.data));
        samples_sent++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the offered sample until it transfers
      end else if (pending_samples.size() > 0 &&
                   !roll(stall_mode == 0 ? 27 : stall_mode == 1 ? 70 : 0)) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= pending_samples.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // long receiver hold, counted down on its own
  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // receiver and result check
  always @(posedge clk) begin
    rss_pkg::result_t exp_res;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_ch.data);
        end else begin
          exp_res = expected_results.pop_front();
          if (out_ch.data !== exp_res) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p actual %p", exp_res, out_ch.data);
          end
        end
      end
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !roll(stall_mode == 0 ? 70 : stall_mode == 1 ? 27 : 0);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_results.size());
      $display("running_sample_statistics verification failed");
      $finish;
    end
  end

  task automatic write_scale(logic [15:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 2'(rss_pkg::RegScaleDivisor);
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    shadow_scale = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_samples.size() > 0 || expected_results.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic random_phase(int unsigned n);
    for (int i = 0; i < n; i++) pending_samples.push_back(random_sample());
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    shadow_count = '0;
    shadow_sum = '0;
    shadow_square_sum = '0;
    shadow_largest = '0;
    shadow_smallest = '0;
    shadow_scale = 16'd1;
    mismatches = 0;
    samples_sent = 0;
    results_seen = 0;
    stall_mode = 0;
    hold_cycles = 0;
    cycle_count = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset scale; zero samples keep the minimum unset
    pending_samples = {24'h0, 24'h0, 24'hFFFFFF, 24'h1, 24'h0, 24'h800000, 24'h7FFFFF,
                       24'hAAAAAA, 24'h555555, 24'h5, 24'h5, 24'hFFFFFF};
    wait_idle();

    write_scale(16'hFFFF);
    random_phase(450);
    wait_idle();

    stall_mode = 1;
    write_scale(16'($urandom_range(65535, 2)));
    hold_cycles = 4000;
    random_phase(450);
    wait_idle();

    // zero divisor behaves as one
    stall_mode = 2;
    write_scale(16'h0000);
    random_phase(450);
    wait_idle();

    stall_mode = 0;
    write_scale(16'h0001);
    random_phase(440);
    wait_idle();

    $display("sent %0d samples, checked %0d results over scales 1, 65535, random, 0",
             samples_sent, results_seen);
    $display("stalls on both sides, one long output hold, %0d mismatches", mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("running_sample_statistics verification clean");
    end else begin
      $display("running_sample_statistics verification failed");
    end
    $finish;
  end
endmodule

// File: filelist.f
design/rss_pkg.sv
design/rss_stream_if.sv
design/rss_front.sv
design/rss_back.sv
design/running_sample_statistics.sv
tb/sv/testbench.sv
